@@ hw/rtl/pcs_pkg.sv @@
// Shared types and constants for the path command to segment converter.
// No dependencies; imported by pcs_front, pcs_back and the top level.
`timescale 1ns / 1ps
`default_nettype none

package pcs_pkg;

   localparam int ARG_W                = 32;
   localparam int FUNC_W               = 3;
   localparam int KIND_W               = 2;
   localparam int SEG_TOTAL_W          = 17;
   localparam int QUEUE_DEPTH          = 4;
   localparam int MAX_SEGMENTS_DEFAULT = 65536;

   // Command codes as they arrive on the request side
   localparam logic [FUNC_W-1:0] FUNC_MOVE_ABS  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_LINE_REL  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_LINE_ABS  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_CLOSE     = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_HLINE_REL = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_VLINE_REL = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_END_CHUNK = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_EOF       = 3'd7;

   // Result kinds as they leave on the response side
   localparam logic [KIND_W-1:0] KIND_SEGMENT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CHUNK_BOX = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FRAME_BOX = 2'd2;

   // Normalized operation handed from the front to the back
   typedef enum logic [2:0] {
      OP_MOVE,
      OP_LINE_REL,
      OP_LINE_ABS,
      OP_CLOSE,
      OP_END_CHUNK,
      OP_EOF
   } op_type;

   // One queued command: relative forms already carry both deltas
   typedef struct packed {
      op_type                  op;
      logic signed [ARG_W-1:0] ax;
      logic signed [ARG_W-1:0] ay;
   } cmd_type;

endpackage

`default_nettype wire

@@ hw/rtl/pcs_front.sv @@
// Front end: decodes path commands into normalized operations and queues them.
// Depends on pcs_pkg (cmd_type, op_type, command codes, QUEUE_DEPTH).
`timescale 1ns / 1ps
`default_nettype none

module pcs_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [pcs_pkg::FUNC_W-1:0]  req_func,
   input  wire logic [pcs_pkg::ARG_W-1:0]   req_arg_x,
   input  wire logic [pcs_pkg::ARG_W-1:0]   req_arg_y,
   output logic                             head_valid,
   output pcs_pkg::cmd_type                 head_cmd,
   input  wire logic                        head_pop
);
   import pcs_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   cmd_type            queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   cmd_type            decoded;
   logic               push;
   logic               pop;

   // Horizontal and vertical lines become relative lines with one zero delta
   always_comb begin
      decoded.ax = req_arg_x;
      decoded.ay = req_arg_y;
      unique case (req_func)
         FUNC_MOVE_ABS:  decoded.op = OP_MOVE;
         FUNC_LINE_REL:  decoded.op = OP_LINE_REL;
         FUNC_LINE_ABS:  decoded.op = OP_LINE_ABS;
         FUNC_CLOSE:     decoded.op = OP_CLOSE;
         FUNC_HLINE_REL: begin
            decoded.op = OP_LINE_REL;
            decoded.ay = '0;
         end
         FUNC_VLINE_REL: begin
            decoded.op = OP_LINE_REL;
            decoded.ax = '0;
            decoded.ay = req_arg_x;
         end
         FUNC_END_CHUNK: decoded.op = OP_END_CHUNK;
         FUNC_EOF:       decoded.op = OP_EOF;
         default:        decoded.op = OP_EOF;
      endcase
   end

   assign req_tready = (count_ff != CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_cmd   = queue_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = head_pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/pcs_back.sv @@
// Back end: path state, box tracking and the registered result stage.
// Depends on pcs_pkg (cmd_type, op_type, result kinds, widths).
`timescale 1ns / 1ps
`default_nettype none

module pcs_back #(
   parameter int MAX_SEGMENTS = pcs_pkg::MAX_SEGMENTS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            head_valid,
   input  wire pcs_pkg::cmd_type                head_cmd,
   output logic                                 head_pop,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [pcs_pkg::KIND_W-1:0]           rsp_kind,
   output logic [pcs_pkg::ARG_W-1:0]            rsp_x0,
   output logic [pcs_pkg::ARG_W-1:0]            rsp_y0,
   output logic [pcs_pkg::ARG_W-1:0]            rsp_x1,
   output logic [pcs_pkg::ARG_W-1:0]            rsp_y1,
   output logic [pcs_pkg::SEG_TOTAL_W-1:0]      rsp_seg_total,
   output logic                                 rsp_last
);
   import pcs_pkg::*;

   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);

   typedef logic signed [ARG_W-1:0] coord_type;

   typedef struct packed {
      coord_type min_x;
      coord_type min_y;
      coord_type max_x;
      coord_type max_y;
   } box_type;

   function automatic coord_type sat_add(coord_type a, coord_type b);
      logic signed [ARG_W:0] s;
      s = {a[ARG_W-1], a} + {b[ARG_W-1], b};
      if (s[ARG_W] != s[ARG_W-1]) begin
         sat_add = s[ARG_W] ? {1'b1, {(ARG_W-1){1'b0}}} : {1'b0, {(ARG_W-1){1'b1}}};
      end else begin
         sat_add = s[ARG_W-1:0];
      end
   endfunction

   function automatic box_type box_grow(box_type b, coord_type x, coord_type y);
      box_type r;
      r = b;
      if (x < b.min_x) r.min_x = x;
      if (y < b.min_y) r.min_y = y;
      if (x > b.max_x) r.max_x = x;
      if (y > b.max_y) r.max_y = y;
      box_grow = r;
   endfunction

   // State
   coord_type          start_x_ff, start_x_in;
   coord_type          start_y_ff, start_y_in;
   coord_type          cur_x_ff, cur_x_in;
   coord_type          cur_y_ff, cur_y_in;
   logic               chunk_open_ff, chunk_open_in;
   box_type            chunk_box_ff, chunk_box_in;
   logic               frame_open_ff, frame_open_in;
   box_type            frame_box_ff, frame_box_in;
   logic [CNT_W-1:0]   seg_count_ff, seg_count_in;
   logic               eof_second_ff, eof_second_in;

   // Result stage
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]        rsp_kind_ff, rsp_kind_in;
   box_type                  rsp_coord_ff, rsp_coord_in;
   logic [SEG_TOTAL_W-1:0]   rsp_total_ff, rsp_total_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                          out_free;
   logic                          is_move;
   logic                          fire;
   coord_type                     nx, ny;
   coord_type                     open_x, open_y;
   box_type                       chunk_cur;
   box_type                       chunk_grown;
   box_type                       frame_merged;
   logic [CNT_W+SEG_TOTAL_W-1:0]  total_ext;

   always_comb begin
      out_free = !rsp_valid_ff || rsp_ready;
      is_move  = (head_cmd.op == OP_MOVE);
      fire     = head_valid && (is_move || out_free);

      unique case (head_cmd.op)
         OP_MOVE, OP_LINE_ABS: begin
            nx = head_cmd.ax;
            ny = head_cmd.ay;
         end
         OP_LINE_REL: begin
            nx = sat_add(cur_x_ff, head_cmd.ax);
            ny = sat_add(cur_y_ff, head_cmd.ay);
         end
         OP_CLOSE: begin
            nx = start_x_ff;
            ny = start_y_ff;
         end
         default: begin
            nx = cur_x_ff;
            ny = cur_y_ff;
         end
      endcase

      // A closed chunk reopens at the current point, or at the move target
      open_x    = is_move ? nx : cur_x_ff;
      open_y    = is_move ? ny : cur_y_ff;
      chunk_cur = chunk_open_ff ? chunk_box_ff : box_type'{open_x, open_y, open_x, open_y};
      chunk_grown = box_grow(chunk_cur, nx, ny);

      frame_merged = chunk_cur;
      if (frame_open_ff) begin
         frame_merged.min_x = (chunk_cur.min_x < frame_box_ff.min_x) ?
                              chunk_cur.min_x : frame_box_ff.min_x;
         frame_merged.min_y = (chunk_cur.min_y < frame_box_ff.min_y) ?
                              chunk_cur.min_y : frame_box_ff.min_y;
         frame_merged.max_x = (chunk_cur.max_x > frame_box_ff.max_x) ?
                              chunk_cur.max_x : frame_box_ff.max_x;
         frame_merged.max_y = (chunk_cur.max_y > frame_box_ff.max_y) ?
                              chunk_cur.max_y : frame_box_ff.max_y;
      end

      total_ext = {{SEG_TOTAL_W{1'b0}}, seg_count_ff};

      // Hold the end-of-file command for its second beat
      head_pop = fire && !((head_cmd.op == OP_EOF) && !eof_second_ff);
   end

   always_comb begin
      start_x_in    = start_x_ff;
      start_y_in    = start_y_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      chunk_open_in = chunk_open_ff;
      chunk_box_in  = chunk_box_ff;
      frame_open_in = frame_open_ff;
      frame_box_in  = frame_box_ff;
      seg_count_in  = seg_count_ff;
      eof_second_in = eof_second_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_coord_in  = rsp_coord_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_last_in   = rsp_last_ff;

      if (fire) begin
         unique case (head_cmd.op)
            OP_MOVE: begin
               start_x_in    = nx;
               start_y_in    = ny;
               cur_x_in      = nx;
               cur_y_in      = ny;
               chunk_box_in  = chunk_grown;
               chunk_open_in = 1'b1;
            end
            OP_LINE_REL, OP_LINE_ABS, OP_CLOSE: begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_SEGMENT;
               rsp_coord_in  = '{cur_x_ff, cur_y_ff, nx, ny};
               rsp_total_in  = '0;
               rsp_last_in   = 1'b1;
               cur_x_in      = nx;
               cur_y_in      = ny;
               chunk_box_in  = chunk_grown;
               chunk_open_in = 1'b1;
               if (seg_count_ff < CNT_MAX) begin
                  seg_count_in = seg_count_ff + 1'b1;
               end
            end
            OP_END_CHUNK: begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_CHUNK_BOX;
               rsp_coord_in  = chunk_cur;
               rsp_total_in  = '0;
               rsp_last_in   = 1'b1;
               frame_box_in  = frame_merged;
               frame_open_in = 1'b1;
               chunk_open_in = 1'b0;
            end
            OP_EOF: begin
               rsp_valid_in = 1'b1;
               if (!eof_second_ff) begin
                  rsp_kind_in   = KIND_CHUNK_BOX;
                  rsp_coord_in  = chunk_cur;
                  rsp_total_in  = '0;
                  rsp_last_in   = 1'b0;
                  frame_box_in  = frame_merged;
                  frame_open_in = 1'b1;
                  chunk_open_in = 1'b0;
                  eof_second_in = 1'b1;
               end else begin
                  rsp_kind_in   = KIND_FRAME_BOX;
                  rsp_coord_in  = frame_box_ff;
                  rsp_total_in  = total_ext[SEG_TOTAL_W-1:0];
                  rsp_last_in   = 1'b1;
                  // Drop all path state for the next file
                  start_x_in    = '0;
                  start_y_in    = '0;
                  cur_x_in      = '0;
                  cur_y_in      = '0;
                  chunk_open_in = 1'b0;
                  chunk_box_in  = '0;
                  frame_open_in = 1'b0;
                  frame_box_in  = '0;
                  seg_count_in  = '0;
                  eof_second_in = 1'b0;
               end
            end
            default: begin
               rsp_valid_in = rsp_valid_ff && !rsp_ready;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff    <= '0;
         start_y_ff    <= '0;
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         chunk_open_ff <= 1'b0;
         chunk_box_ff  <= '0;
         frame_open_ff <= 1'b0;
         frame_box_ff  <= '0;
         seg_count_ff  <= '0;
         eof_second_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         start_x_ff    <= start_x_in;
         start_y_ff    <= start_y_in;
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         chunk_open_ff <= chunk_open_in;
         chunk_box_ff  <= chunk_box_in;
         frame_open_ff <= frame_open_in;
         frame_box_ff  <= frame_box_in;
         seg_count_ff  <= seg_count_in;
         eof_second_ff <= eof_second_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff  <= rsp_kind_in;
      rsp_coord_ff <= rsp_coord_in;
      rsp_total_ff <= rsp_total_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_x0        = rsp_coord_ff.min_x;
   assign rsp_y0        = rsp_coord_ff.min_y;
   assign rsp_x1        = rsp_coord_ff.max_x;
   assign rsp_y1        = rsp_coord_ff.max_y;
   assign rsp_seg_total = rsp_total_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

`default_nettype wire

@@ hw/rtl/path_commands_to_segments.sv @@
// Top level: path commands in, line segments and bounding boxes out.
// Depends on pcs_pkg, pcs_front and pcs_back.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Dir | tdata (low bit up)                         | tuser | tlast
// ----------+-----+--------------------------------------------+-------+------
// req_      | in  | arg_x[31:0], arg_y[63:32], pad to 64       | func  | -
// rsp_      | out | x0, y0, x1, y1, seg_total[144:128], pad 152 | kind  | last
//
// Flow: one command per cycle sustained while rsp_tready is high; end of file
// stays at the queue head until both of its result beats are issued. A result
// is registered: its command passes through a queue entry and then through the
// result register.
// Reset: synchronous; clears the queue pointers, the path state and the result
// valid directly, with no clearing pass.
// Stalls: a four-entry queue separates the decoder from the executing back end,
// so req_tready drops only when the queue is full; moves retire even while the
// result register waits on rsp_tready.

module path_commands_to_segments #(
   parameter int MAX_SEGMENTS = pcs_pkg::MAX_SEGMENTS_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   // Command beats
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [63:0]   req_tdata,   // arg_x[31:0], arg_y[63:32]
   input  wire logic [2:0]    req_tuser,   // func[2:0]
   // Result beats
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [151:0]       rsp_tdata,   // x0, y0, x1, y1, seg_total[144:128], zeros
   output logic [1:0]         rsp_tuser,   // kind[1:0]
   output logic               rsp_tlast
);
   import pcs_pkg::*;

   logic                    head_valid;
   cmd_type                 head_cmd;
   logic                    head_pop;
   logic [ARG_W-1:0]        out_x0, out_y0, out_x1, out_y1;
   logic [SEG_TOTAL_W-1:0]  out_total;

   // Decode and queue commands
   pcs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .req_arg_x  (req_tdata[31:0]),
      .req_arg_y  (req_tdata[63:32]),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .head_pop   (head_pop)
   );

   // Execute commands and hold the result beat
   pcs_back #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_cmd      (head_cmd),
      .head_pop      (head_pop),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_kind      (rsp_tuser),
      .rsp_x0        (out_x0),
      .rsp_y0        (out_y0),
      .rsp_x1        (out_x1),
      .rsp_y1        (out_y1),
      .rsp_seg_total (out_total),
      .rsp_last      (rsp_tlast)
   );

   // Pack the result fields, first field lowest
   assign rsp_tdata = {7'b0, out_total, out_y1, out_x1, out_y0, out_x0};

endmodule

`default_nettype wire

@@ verif/path_commands_to_segments_tb.sv @@
// Self-checking bench for path_commands_to_segments: command beats in, segment and box beats out.
// Depends on pcs_pkg and the RTL of the block; a built-in path tracker predicts every result.
`timescale 1ns / 1ps

module path_commands_to_segments_tb;

   import pcs_pkg::*;

   // Command codes as they travel on req_tuser
   localparam logic [FUNC_W-1:0] CMD_MOVE      = FUNC_MOVE_ABS;
   localparam logic [FUNC_W-1:0] CMD_LINE_REL  = FUNC_LINE_REL;
   localparam logic [FUNC_W-1:0] CMD_LINE_ABS  = FUNC_LINE_ABS;
   localparam logic [FUNC_W-1:0] CMD_CLOSE     = FUNC_CLOSE;
   localparam logic [FUNC_W-1:0] CMD_HLINE_REL = FUNC_HLINE_REL;
   localparam logic [FUNC_W-1:0] CMD_VLINE_REL = FUNC_VLINE_REL;
   localparam logic [FUNC_W-1:0] CMD_END_CHUNK = FUNC_END_CHUNK;
   localparam logic [FUNC_W-1:0] CMD_EOF       = FUNC_EOF;

   localparam int SEG_CAP = MAX_SEGMENTS_DEFAULT;

   // Q16.16 landmarks
   localparam logic [ARG_W-1:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [ARG_W-1:0] Q_MIN = 32'h8000_0000;
   localparam logic [ARG_W-1:0] Q_ONE = 32'h0001_0000;
   localparam logic [ARG_W-1:0] Q_NEG = 32'hFFFF_FFFF;

   localparam int RANDOM_ITEMS = 1250;

   typedef struct packed {
      logic [KIND_W-1:0]       kind;
      logic signed [ARG_W-1:0] x0;
      logic signed [ARG_W-1:0] y0;
      logic signed [ARG_W-1:0] x1;
      logic signed [ARG_W-1:0] y1;
      logic [SEG_TOTAL_W-1:0]  total;
      logic                    last;
   } shape_type;

   typedef struct packed {
      logic signed [ARG_W-1:0] lx;
      logic signed [ARG_W-1:0] ly;
      logic signed [ARG_W-1:0] hx;
      logic signed [ARG_W-1:0] hy;
   } box_type;

   // One directed row: command plus, where obvious, the first result typed in
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ARG_W-1:0]  ax;
      logic [ARG_W-1:0]  ay;
      logic              typed;
      shape_type         want;
   } step_type;

   localparam shape_type UNTYPED = '0;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [2*ARG_W-1:0]         req_tdata;   // arg_x[31:0], arg_y[63:32]
   logic [FUNC_W-1:0]          req_tuser;   // func[2:0]
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [151:0]               rsp_tdata;   // x0, y0, x1, y1, seg_total[144:128], zeros
   logic [KIND_W-1:0]          rsp_tuser;   // kind[1:0]
   logic                       rsp_tlast;

   // Idling on both sides is switched off while this is high
   bit quiet = 1'b0;
   int bad_beats = 0;

   // Tracker state: subpath start, pen, chunk and frame boxes, segment tally
   logic signed [ARG_W-1:0] sub_x, sub_y, pen_x, pen_y;
   box_type chunk_bb, frame_bb;
   bit   chunk_live, frame_live;
   int   seg_tally;

   shape_type pending_shapes[$];

   path_commands_to_segments #(
      .MAX_SEGMENTS(SEG_CAP)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Directed rows: extremes, every command, saturation, empty chunk, line
   // before any move, chunk opened by a move, end of file right after a clear.
   step_type plan [25] = '{
      // line before move starts from the origin
      '{CMD_LINE_REL, Q_ONE, 32'h0002_0000, 1'b1,
        '{KIND_SEGMENT, 32'h0, 32'h0, Q_ONE, 32'h0002_0000, 17'd0, 1'b1}},
      '{CMD_MOVE, Q_MAX, Q_MAX, 1'b0, UNTYPED},
      // clamp at the top of the range
      '{CMD_LINE_REL, Q_MAX, Q_ONE, 1'b1,
        '{KIND_SEGMENT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 17'd0, 1'b1}},
      '{CMD_MOVE, Q_MIN, Q_MIN, 1'b0, UNTYPED},
      // clamp at the bottom of the range
      '{CMD_LINE_REL, Q_MIN, Q_MIN, 1'b1,
        '{KIND_SEGMENT, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 17'd0, 1'b1}},
      // one-argument forms ignore arg_y
      '{CMD_HLINE_REL, Q_MAX, 32'hDEAD_BEEF, 1'b1,
        '{KIND_SEGMENT, Q_MIN, Q_MIN, Q_NEG, Q_MIN, 17'd0, 1'b1}},
      '{CMD_VLINE_REL, Q_MAX, 32'h1234_5678, 1'b1,
        '{KIND_SEGMENT, Q_NEG, Q_MIN, Q_NEG, Q_NEG, 17'd0, 1'b1}},
      '{CMD_LINE_ABS, 32'h7FFF_0000, 32'h8001_0000, 1'b0, UNTYPED},
      '{CMD_CLOSE, Q_NEG, Q_NEG, 1'b0, UNTYPED},
      // chunk spans the whole range by now
      '{CMD_END_CHUNK, 32'h0, 32'h0, 1'b1,
        '{KIND_CHUNK_BOX, Q_MIN, Q_MIN, Q_MAX, Q_MAX, 17'd0, 1'b1}},
      // empty chunk collapses onto the pen
      '{CMD_END_CHUNK, Q_MAX, Q_MIN, 1'b1,
        '{KIND_CHUNK_BOX, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 17'd0, 1'b1}},
      '{CMD_VLINE_REL, Q_MIN, 32'h0, 1'b0, UNTYPED},
      '{CMD_HLINE_REL, Q_MIN, Q_NEG, 1'b0, UNTYPED},
      '{CMD_LINE_ABS, Q_MAX, Q_MIN, 1'b0, UNTYPED},
      '{CMD_MOVE, 32'h0000_8000, 32'hFFFF_0000, 1'b0, UNTYPED},
      '{CMD_CLOSE, 32'h0, 32'h0, 1'b0, UNTYPED},
      '{CMD_EOF, Q_NEG, Q_NEG, 1'b0, UNTYPED},
      // end of file on a cleared path: degenerate box at the origin
      '{CMD_EOF, 32'h0, 32'h0, 1'b1,
        '{KIND_CHUNK_BOX, 32'h0, 32'h0, 32'h0, 32'h0, 17'd0, 1'b0}},
      '{CMD_CLOSE, Q_MAX, Q_MAX, 1'b1,
        '{KIND_SEGMENT, 32'h0, 32'h0, 32'h0, 32'h0, 17'd0, 1'b1}},
      '{CMD_LINE_ABS, Q_MIN, Q_MAX, 1'b0, UNTYPED},
      '{CMD_END_CHUNK, 32'h0, 32'h0, 1'b0, UNTYPED},
      '{CMD_MOVE, Q_ONE, Q_ONE, 1'b0, UNTYPED},
      // a move opens the next chunk at its target
      '{CMD_END_CHUNK, 32'h0, 32'h0, 1'b1,
        '{KIND_CHUNK_BOX, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 17'd0, 1'b1}},
      '{CMD_EOF, 32'h0, 32'h0, 1'b0, UNTYPED},
      '{CMD_LINE_REL, Q_NEG, Q_NEG, 1'b0, UNTYPED}
   };

   task automatic flag_mismatch(input string what);
      // Keep the log short on a badly broken block, but count everything
      if (bad_beats < 100)
         $display("%0t ns: mismatch: %s", $time, what);
      bad_beats++;
   endtask

   // Append one expected result beat
   function automatic void expect_shape(input shape_type s);
      pending_shapes = {pending_shapes, s};
   endfunction

   function automatic logic signed [ARG_W-1:0] clamp_sum(input logic signed [ARG_W-1:0] a,
                                                         input logic signed [ARG_W-1:0] b);
      longint s;
      s = longint'(a) + longint'(b);
      if (s > 64'sd2147483647)
         return Q_MAX;
      if (s < -64'sd2147483648)
         return Q_MIN;
      return s[ARG_W-1:0];
   endfunction

   function automatic box_type widen(input box_type b, input logic signed [ARG_W-1:0] x,
                                     input logic signed [ARG_W-1:0] y);
      if (x < b.lx) b.lx = x;
      if (y < b.ly) b.ly = y;
      if (x > b.hx) b.hx = x;
      if (y > b.hy) b.hy = y;
      return b;
   endfunction

   function automatic void clear_path();
      sub_x = '0; sub_y = '0; pen_x = '0; pen_y = '0;
      chunk_bb = '0; frame_bb = '0;
      chunk_live = 1'b0; frame_live = 1'b0;
      seg_tally = 0;
   endfunction

   // Open the chunk box at the pen if no chunk is open yet
   function automatic void open_chunk();
      if (!chunk_live) begin
         chunk_bb = '{pen_x, pen_y, pen_x, pen_y};
         chunk_live = 1'b1;
      end
   endfunction

   // Advance the tracker by one accepted command and queue the results it causes
   function automatic void trace_command(input logic [FUNC_W-1:0] func,
                                         input logic signed [ARG_W-1:0] ax,
                                         input logic signed [ARG_W-1:0] ay);
      logic signed [ARG_W-1:0] nx, ny;
      nx = pen_x;
      ny = pen_y;
      case (func)
         CMD_MOVE: begin
            sub_x = ax; sub_y = ay;
            pen_x = ax; pen_y = ay;
            open_chunk();
            chunk_bb = widen(chunk_bb, pen_x, pen_y);
            return;
         end
         CMD_LINE_REL: begin
            nx = clamp_sum(pen_x, ax);
            ny = clamp_sum(pen_y, ay);
         end
         CMD_LINE_ABS: begin
            nx = ax;
            ny = ay;
         end
         CMD_CLOSE: begin
            nx = sub_x;
            ny = sub_y;
         end
         CMD_HLINE_REL: nx = clamp_sum(pen_x, ax);
         CMD_VLINE_REL: ny = clamp_sum(pen_y, ax);
         default: begin
            // end of chunk or end of file: close the chunk into the frame
            open_chunk();
            expect_shape('{KIND_CHUNK_BOX, chunk_bb.lx, chunk_bb.ly, chunk_bb.hx,
                           chunk_bb.hy, 17'd0, func == CMD_END_CHUNK});
            if (!frame_live) begin
               frame_bb = chunk_bb;
               frame_live = 1'b1;
            end else begin
               frame_bb = widen(widen(frame_bb, chunk_bb.lx, chunk_bb.ly),
                                chunk_bb.hx, chunk_bb.hy);
            end
            chunk_live = 1'b0;
            if (func == CMD_EOF) begin
               expect_shape('{KIND_FRAME_BOX, frame_bb.lx, frame_bb.ly, frame_bb.hx,
                              frame_bb.hy, seg_tally[SEG_TOTAL_W-1:0], 1'b1});
               clear_path();
            end
            return;
         end
      endcase
      open_chunk();
      expect_shape('{KIND_SEGMENT, pen_x, pen_y, nx, ny, 17'd0, 1'b1});
      pen_x = nx;
      pen_y = ny;
      chunk_bb = widen(chunk_bb, pen_x, pen_y);
      if (seg_tally < SEG_CAP)
         seg_tally++;
   endfunction

   // Coordinates: range ends, the values around zero, small offsets, raw bits
   function automatic logic [ARG_W-1:0] pick_coord();
      case ($urandom_range(9))
         0: return Q_MIN;
         1: return Q_MAX;
         2: return '0;
         3: return Q_NEG;
         4, 5, 6: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [FUNC_W-1:0] pick_func();
      int r;
      r = $urandom_range(99);
      if (r < 12) return CMD_MOVE;
      if (r < 30) return CMD_LINE_REL;
      if (r < 45) return CMD_LINE_ABS;
      if (r < 53) return CMD_CLOSE;
      if (r < 65) return CMD_HLINE_REL;
      if (r < 77) return CMD_VLINE_REL;
      if (r < 90) return CMD_END_CHUNK;
      return CMD_EOF;
   endfunction

   // Drive one command beat and hold it until the block takes it. Handshake
   // state is read at the falling edge, where both sides are settled; the
   // task returns on the rising edge that accepts the beat.
   task automatic send_command(input logic [FUNC_W-1:0] func, input logic [ARG_W-1:0] ax,
                               input logic [ARG_W-1:0] ay);
      while (!quiet && $urandom_range(99) < 33) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ay, ax};
      req_tuser  <= func;
      @(negedge clock);
      while (!req_tready)
         @(negedge clock);
      @(posedge clock);
   endtask

   // Result side: stall at random unless idling is switched off
   always @(posedge clock)
      rsp_tready <= quiet || ($urandom_range(99) >= 33);

   // Check every accepted result beat against the oldest expectation
   always @(negedge clock) begin
      shape_type seen, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = '{rsp_tuser, rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                  rsp_tdata[127:96], rsp_tdata[144:128], rsp_tlast};
         if (pending_shapes.size() == 0) begin
            flag_mismatch($sformatf("result beat of kind %0d with nothing pending", seen.kind));
         end else begin
            want = pending_shapes.pop_front();
            if (seen.kind != want.kind)
               flag_mismatch($sformatf("kind %0d, want %0d", seen.kind, want.kind));
            if (seen.x0 != want.x0)
               flag_mismatch($sformatf("x0 %h, want %h", seen.x0, want.x0));
            if (seen.y0 != want.y0)
               flag_mismatch($sformatf("y0 %h, want %h", seen.y0, want.y0));
            if (seen.x1 != want.x1)
               flag_mismatch($sformatf("x1 %h, want %h", seen.x1, want.x1));
            if (seen.y1 != want.y1)
               flag_mismatch($sformatf("y1 %h, want %h", seen.y1, want.y1));
            if (seen.total != want.total)
               flag_mismatch($sformatf("seg_total %0d, want %0d", seen.total, want.total));
            if (seen.last != want.last)
               flag_mismatch($sformatf("last %0d, want %0d", seen.last, want.last));
         end
      end
   end

   initial begin
      int slot;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= CMD_MOVE;
      clear_path();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed rows; a typed-in result stands in for the tracker's first one
      foreach (plan[i]) begin
         send_command(plan[i].func, plan[i].ax, plan[i].ay);
         slot = pending_shapes.size();
         trace_command(plan[i].func, plan[i].ax, plan[i].ay);
         if (plan[i].typed)
            pending_shapes[slot] = plan[i].want;
      end

      // Random mix with a stretch of back-to-back traffic in the middle
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         logic [FUNC_W-1:0] f;
         logic [ARG_W-1:0]  ax, ay;
         quiet = (n >= 400 && n < 700);
         f  = pick_func();
         ax = pick_coord();
         ay = pick_coord();
         send_command(f, ax, ay);
         trace_command(f, ax, ay);
      end
      quiet = 1'b0;

      // Flush the open frame
      send_command(CMD_EOF, '0, '0);
      trace_command(CMD_EOF, '0, '0);
      req_tvalid <= 1'b0;

      // Drain, then keep the clock running so that any stray beat can show up
      while (pending_shapes.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (bad_beats == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin
      #30_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
